/* hdl/byte_ring_fifo_with_overflow_policy_macros.svh */
// assertion macros used by the byte ring fifo control module
`ifndef BYTE_RING_FIFO_WITH_OVERFLOW_POLICY_MACROS_SVH
`define BYTE_RING_FIFO_WITH_OVERFLOW_POLICY_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define BRF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// condition in one cycle implies a consequence in the next
`define BRF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BRF_ASSERT(lbl, prop, msg)
`define BRF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/brf_pkg.sv */
// types, codes and defaults for the byte ring fifo
package brf_pkg;

   // parameter defaults
   localparam int DEPTH_DEF    = 1024;
   localparam int MAX_READ_DEF = 64;

   // fixed field widths
   localparam int DATA_W  = 8;
   localparam int LEN_W   = 11;
   localparam int RCNT_W  = 7;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // reset value of the capacity register
   localparam logic [LEN_W-1:0] CAP_RESET = 11'd1024;

   // commands
   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_PUT   = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_COUNT = 2'd2;

   // put status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_BAD_LEN = 2'd1;
   localparam logic [1:0] STAT_NO_ROOM = 2'd2;
   localparam logic [1:0] STAT_OUTSIDE = 2'd3;

   // register indexes
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_MODE     = 1'b1;

   // overflow modes
   localparam logic MODE_REJECT = 1'b0;
   localparam logic MODE_DROP   = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic              start_block;
      logic [LEN_W-1:0]  block_len;
      logic [DATA_W-1:0] data;
      logic [RCNT_W-1:0] read_count;
      logic              consume;
      logic              no_copy;
   } brf_req_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        status;
      logic [DATA_W-1:0] read_data;
      logic [RCNT_W-1:0] returned_count;
      logic [LEN_W-1:0]  dropped_count;
      logic [LEN_W-1:0]  fill_level;
      logic              last;
   } brf_rsp_type;

   // configuration seen by the control logic
   typedef struct packed {
      logic [LEN_W-1:0] capacity;
      logic             overflow_mode;
      logic             clear;
   } brf_cfg_type;

endpackage

/* hdl/brf_csr.sv */
// configuration registers behind the apb-style port
module brf_csr
   import brf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output brf_cfg_type       cfg
);

   logic [LEN_W-1:0] capacity_ff, capacity_in;
   logic             mode_ff, mode_in;
   logic             wr_stb;
   logic             reg_idx;

   assign pready  = 1'b1;
   assign wr_stb  = psel && penable && pwrite;
   assign reg_idx = paddr[2];

   // register writes
   always_comb begin
      capacity_in = capacity_ff;
      mode_in     = mode_ff;
      if (wr_stb) begin
         case (reg_idx)
            REG_CAPACITY: capacity_in = pwdata[LEN_W-1:0];
            REG_MODE:     mode_in     = pwdata[0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         mode_ff     <= MODE_REJECT;
      end else begin
         capacity_ff <= capacity_in;
         mode_ff     <= mode_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         REG_CAPACITY: prdata = CSR_DW'(capacity_ff);
         REG_MODE:     prdata = CSR_DW'(mode_ff);
         default:      prdata = '0;
      endcase
   end

   // a capacity write empties the ring at the same edge
   assign cfg.capacity      = capacity_ff;
   assign cfg.overflow_mode = mode_ff;
   assign cfg.clear         = wr_stb && (reg_idx == REG_CAPACITY);

endmodule

/* hdl/brf_ram.sv */
// byte storage, one write and one registered read port
module brf_ram
   import brf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, data holds while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/brf_ctrl.sv */
// pointer, fill and block bookkeeping, read sequencer and output register
`include "byte_ring_fifo_with_overflow_policy_macros.svh"

module brf_ctrl
   import brf_pkg::*;
#(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int MAX_READ = MAX_READ_DEF,
   localparam int PTR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  brf_cfg_type       cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  brf_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output brf_rsp_type       rsp_data,
   output logic              ram_we,
   output logic [PTR_W-1:0]  ram_waddr,
   output logic [DATA_W-1:0] ram_wdata,
   output logic              ram_re,
   output logic [PTR_W-1:0]  ram_raddr,
   input  logic [DATA_W-1:0] ram_rdata
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  brem_ff, brem_in;
   logic [PTR_W-1:0]  addr_ff, addr_in;
   logic [RCNT_W-1:0] n_ff, n_in;
   logic [RCNT_W-1:0] iss_ff, iss_in;
   logic [RCNT_W-1:0] dlv_ff, dlv_in;
   logic              pend_ff, pend_in;
   logic              out_valid_ff, out_valid_in;
   brf_rsp_type       out_ff, out_in;

   logic [CNT_W-1:0]  cap_eff;
   logic              out_free;
   logic              req_acc;

   // put path
   logic              bad_len;
   logic [CNT_W-1:0]  len_c;
   logic [CNT_W-1:0]  space;
   logic              short_room;
   logic [CNT_W-1:0]  drop_raw;
   logic [CNT_W-1:0]  drop;
   logic [1:0]        put_status;
   logic [CNT_W-1:0]  put_drop;
   logic              put_store;
   logic              put_open;
   logic [CNT_W-1:0]  fill_base;
   logic [CNT_W-1:0]  rem_base;
   logic [PTR_W-1:0]  rp_put;
   logic [CNT_W-1:0]  brem_put;
   logic [PTR_W-1:0]  wp_fix;

   // read path
   logic [RCNT_W-1:0] n_max;
   logic [RCNT_W-1:0] n_clip;
   logic [PTR_W-1:0]  rd_start;
   logic [PTR_W-1:0]  rp_rd;
   logic [CNT_W-1:0]  fill_rd;
   logic              count_only;
   logic              rd_issue;
   logic              rd_move;
   logic              rd_last;

   // pointer advance with wrap at the capacity
   function automatic logic [PTR_W-1:0] wrap_add(
      input logic [PTR_W-1:0] p,
      input logic [CNT_W-1:0] k,
      input logic [CNT_W-1:0] c
   );
      logic [SUM_W-1:0] s;
      s = SUM_W'(p) + SUM_W'(k);
      if (s >= SUM_W'(c)) s = s - SUM_W'(c);
      if (s >= SUM_W'(c)) s = '0;
      return PTR_W'(s);
   endfunction

   // capacity clamped to 1..DEPTH
   always_comb begin
      if (cfg.capacity == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(cfg.capacity) > 32'(DEPTH)) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = CNT_W'(cfg.capacity);
      end
   end

   // handshake
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_acc   = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // block start checks and drop of oldest bytes
   assign bad_len    = (req_data.block_len == '0) ||
                       (32'(req_data.block_len) > 32'(cap_eff));
   assign len_c      = CNT_W'(req_data.block_len);
   assign space      = (fill_ff < cap_eff) ? (cap_eff - fill_ff) : '0;
   assign short_room = len_c > space;
   assign drop_raw   = len_c - space;
   assign drop       = (drop_raw > fill_ff) ? fill_ff : drop_raw;
   assign wp_fix     = (wp_ff >= cap_eff) ? '0 : wp_ff;

   // put decision
   always_comb begin
      put_status = STAT_OK;
      put_drop   = '0;
      put_store  = 1'b0;
      put_open   = 1'b0;
      fill_base  = fill_ff;
      rem_base   = brem_ff;
      rp_put     = rp_ff;
      brem_put   = brem_ff;
      if (req_data.start_block) begin
         brem_put = '0;
         if (bad_len) begin
            put_status = STAT_BAD_LEN;
         end else if (short_room && (cfg.overflow_mode == MODE_REJECT)) begin
            put_status = STAT_NO_ROOM;
         end else begin
            if (short_room) begin
               put_drop  = drop;
               rp_put    = wrap_add(rp_ff, drop, cap_eff);
               fill_base = fill_ff - drop;
            end
            put_open = 1'b1;
            rem_base = len_c;
         end
      end else if (brem_ff == '0) begin
         put_status = STAT_OUTSIDE;
      end else begin
         put_open = 1'b1;
      end
      if (put_open) begin
         if (fill_base >= cap_eff) begin
            put_status = STAT_NO_ROOM;
            brem_put   = '0;
         end else begin
            put_store = 1'b1;
            brem_put  = rem_base - CNT_W'(1);
         end
      end
   end

   // read length clipping and pointer update
   assign n_max      = (32'(req_data.read_count) > 32'(MAX_READ)) ?
                       RCNT_W'(MAX_READ) : req_data.read_count;
   assign n_clip     = (32'(n_max) > 32'(fill_ff)) ? RCNT_W'(fill_ff) : n_max;
   assign rd_start   = (rp_ff >= cap_eff) ? '0 : rp_ff;
   assign rp_rd      = wrap_add(rd_start, CNT_W'(n_clip), cap_eff);
   assign fill_rd    = req_data.consume ? (fill_ff - CNT_W'(n_clip)) : fill_ff;
   assign count_only = req_data.no_copy || (n_clip == '0);

   // read streaming: issue a memory read while reads remain and no fetched byte waits or it can move on
   assign rd_move  = (state_ff == ST_READ) && pend_ff && out_free;
   assign rd_issue = (state_ff == ST_READ) && (iss_ff != n_ff) && (!pend_ff || out_free);
   assign rd_last  = (dlv_ff + RCNT_W'(1)) == n_ff;

   assign ram_we    = (state_ff == ST_IDLE) && req_acc && (req_data.cmd == CMD_PUT) &&
                      put_store;
   assign ram_waddr = wp_fix;
   assign ram_wdata = req_data.data;
   assign ram_re    = rd_issue;
   assign ram_raddr = addr_ff;

   // next state
   always_comb begin
      state_in     = state_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      brem_in      = brem_ff;
      addr_in      = addr_ff;
      n_in         = n_ff;
      iss_in       = iss_ff;
      dlv_in       = dlv_ff;
      pend_in      = pend_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_data.cmd == CMD_PUT) begin
                  rp_in   = rp_put;
                  fill_in = fill_base + CNT_W'(put_store);
                  brem_in = brem_put;
                  if (put_store) begin
                     wp_in = wrap_add(wp_fix, CNT_W'(1), cap_eff);
                  end
                  out_in.kind           = KIND_PUT;
                  out_in.status         = put_status;
                  out_in.read_data      = '0;
                  out_in.returned_count = '0;
                  out_in.dropped_count  = LEN_W'(put_drop);
                  out_in.fill_level     = LEN_W'(fill_base + CNT_W'(put_store));
                  out_in.last           = 1'b1;
                  out_valid_in          = 1'b1;
               end else begin
                  if (req_data.consume) begin
                     rp_in   = rp_rd;
                     fill_in = fill_rd;
                  end
                  if (count_only) begin
                     out_in.kind           = KIND_COUNT;
                     out_in.status         = STAT_OK;
                     out_in.read_data      = '0;
                     out_in.returned_count = n_clip;
                     out_in.dropped_count  = '0;
                     out_in.fill_level     = LEN_W'(fill_rd);
                     out_in.last           = 1'b1;
                     out_valid_in          = 1'b1;
                  end else begin
                     state_in = ST_READ;
                     addr_in  = rd_start;
                     n_in     = n_clip;
                     iss_in   = '0;
                     dlv_in   = '0;
                  end
               end
            end
         end
         ST_READ: begin
            if (rd_issue) begin
               addr_in = wrap_add(addr_ff, CNT_W'(1), cap_eff);
               iss_in  = iss_ff + RCNT_W'(1);
               pend_in = 1'b1;
            end else if (rd_move) begin
               pend_in = 1'b0;
            end
            if (rd_move) begin
               out_in.kind           = KIND_BYTE;
               out_in.status         = STAT_OK;
               out_in.read_data      = ram_rdata;
               out_in.returned_count = n_ff;
               out_in.dropped_count  = '0;
               out_in.fill_level     = LEN_W'(fill_ff);
               out_in.last           = rd_last;
               out_valid_in          = 1'b1;
               dlv_in                = dlv_ff + RCNT_W'(1);
               if (rd_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            pend_in  = 1'b0;
         end
      endcase
      // capacity write empties the ring
      if (cfg.clear) begin
         rp_in   = '0;
         wp_in   = '0;
         fill_in = '0;
         brem_in = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         brem_ff      <= '0;
         n_ff         <= '0;
         iss_ff       <= '0;
         dlv_ff       <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         brem_ff      <= brem_in;
         n_ff         <= n_in;
         iss_ff       <= iss_in;
         dlv_ff       <= dlv_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      out_ff  <= out_in;
   end

   // checks
   `BRF_ASSERT(a_fill_in_cap, fill_ff <= cap_eff, "fill level above capacity")
   `BRF_ASSERT(a_ptr_in_cap, (rp_ff < cap_eff) && (wp_ff < cap_eff), "pointer beyond capacity")
   `BRF_ASSERT(a_rd_counts, (state_ff == ST_READ) |-> ((iss_ff == dlv_ff + RCNT_W'(pend_ff)) && (iss_ff <= n_ff)), "read issue and delivery counts disagree")
   `BRF_ASSERT(a_idle_no_pend, (state_ff == ST_IDLE) |-> !pend_ff, "fetched byte left behind")
   `BRF_ASSERT_NEXT(a_last_ends_read, rd_move && rd_last, (state_ff == ST_IDLE) && out_valid_ff && out_ff.last, "final byte did not end the read")

endmodule

/* hdl/byte_ring_fifo_with_overflow_policy.sv */
// top level of the byte ring fifo with overflow policy
//
//   port group  direction  handshake            payload
//   req_*       in         req_valid/req_stall  brf_req_type
//   rsp_*       out        rsp_valid/rsp_stall  brf_rsp_type
//   csr_*       in/out     apb-style write      capacity, overflow_mode
//
// a put or a count-only read gives one result; a read of n bytes stalls req until its
// last byte is out, one byte per cycle via the single memory read port unless stalled.
// synchronous reset clears pointers, fill count and block state; storage is not cleared.
// results sit in one output register, so the next item is taken while a result is taken.
// rsp_stall holds the output register and the read sequencer until it drops.
module byte_ring_fifo_with_overflow_policy
   import brf_pkg::*;
#(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int MAX_READ = MAX_READ_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  brf_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output brf_rsp_type       rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int PTR_W = $clog2(DEPTH);

   brf_cfg_type       cfg;
   logic              ram_we;
   logic [PTR_W-1:0]  ram_waddr;
   logic [DATA_W-1:0] ram_wdata;
   logic              ram_re;
   logic [PTR_W-1:0]  ram_raddr;
   logic [DATA_W-1:0] ram_rdata;

   // configuration registers
   brf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // byte storage
   brf_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // control and output register
   brf_ctrl #(
      .DEPTH    (DEPTH),
      .MAX_READ (MAX_READ)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the byte ring fifo: directed and random blocks and reads against a ring predictor
module tb_top;
   import brf_pkg::*;

   localparam int RING_DEPTH   = DEPTH_DEF;
   localparam int RING_AW      = $clog2(RING_DEPTH);
   localparam int READ_MAX     = MAX_READ_DEF;
   localparam int CYCLE_LIMIT  = 800000;
   localparam int DRAIN_CYCLES = 2 * READ_MAX + 16;
   localparam int PHASE_ITEMS  = 48;

   // ring predictor and store of expected results
   class ring_scoreboard;
      logic [DATA_W-1:0] byte_store [RING_DEPTH];
      int unsigned       rd_ptr;
      int unsigned       wr_ptr;
      int unsigned       fill;
      int unsigned       block_left;
      logic [LEN_W-1:0]  capacity_reg;
      logic              mode_reg;
      brf_rsp_type       expected_results [$];
      int unsigned       errors;

      function new();
         capacity_reg = CAP_RESET;
         mode_reg     = MODE_REJECT;
         errors       = 0;
         empty_ring();
      endfunction

      function void empty_ring();
         rd_ptr     = 0;
         wr_ptr     = 0;
         fill       = 0;
         block_left = 0;
      endfunction

      // capacity register clamped to 1..depth
      function int unsigned eff_cap();
         int unsigned c;
         c = 32'(capacity_reg);
         if (c == 0) c = 1;
         if (c > RING_DEPTH) c = RING_DEPTH;
         return c;
      endfunction

      // pointer step with wrap at the capacity in use
      function int unsigned ring_advance(int unsigned p, int unsigned k, int unsigned cap);
         p += k;
         if (p >= cap) p -= cap;
         if (p >= cap) p = 0;
         return p;
      endfunction

      task report(string msg);
         errors++;
         $display("%0t: mismatch: %s", $realtime, msg);
      endtask

      function void set_config(logic idx, logic [CSR_DW-1:0] value);
         if (idx == REG_CAPACITY) begin
            capacity_reg = value[LEN_W-1:0];
            empty_ring();
         end else begin
            mode_reg = value[0];
         end
      endfunction

      function void push_result(logic [1:0] kind, logic [1:0] status, logic [DATA_W-1:0] value,
                                int unsigned count, int unsigned dropped, logic last);
         brf_rsp_type e;
         e.kind           = kind;
         e.status         = status;
         e.read_data      = value;
         e.returned_count = RCNT_W'(count);
         e.dropped_count  = LEN_W'(dropped);
         e.fill_level     = LEN_W'(fill);
         e.last           = last;
         expected_results.push_back(e);
      endfunction

      // work out the results of one accepted item
      task note_request(brf_req_type r);
         int unsigned       cap;
         int unsigned       len;
         int unsigned       space;
         int unsigned       dropped;
         int unsigned       n;
         int unsigned       p;
         logic [DATA_W-1:0] got_bytes [$];
         cap     = eff_cap();
         dropped = 0;
         if (r.cmd == CMD_PUT) begin
            len = 32'(r.block_len);
            if (r.start_block) begin
               block_left = 0;
               if (len == 0 || len > cap) begin
                  push_result(KIND_PUT, STAT_BAD_LEN, '0, 0, 0, 1'b1);
                  return;
               end
               space = (fill < cap) ? cap - fill : 0;
               // short of room: reject or drop the oldest bytes
               if (len > space) begin
                  if (mode_reg == MODE_REJECT) begin
                     push_result(KIND_PUT, STAT_NO_ROOM, '0, 0, 0, 1'b1);
                     return;
                  end
                  dropped = len - space;
                  if (dropped > fill) dropped = fill;
                  rd_ptr = ring_advance(rd_ptr, dropped, cap);
                  fill  -= dropped;
               end
               block_left = len;
            end else if (block_left == 0) begin
               push_result(KIND_PUT, STAT_OUTSIDE, '0, 0, 0, 1'b1);
               return;
            end
            if (fill >= cap) begin
               block_left = 0;
               push_result(KIND_PUT, STAT_NO_ROOM, '0, 0, dropped, 1'b1);
               return;
            end
            if (wr_ptr >= cap) wr_ptr = 0;
            byte_store[RING_AW'(wr_ptr)] = r.data;
            wr_ptr = ring_advance(wr_ptr, 1, cap);
            fill++;
            block_left--;
            push_result(KIND_PUT, STAT_OK, '0, 0, dropped, 1'b1);
         end else begin
            // read clipped to the max read size and the fill level
            n = 32'(r.read_count);
            if (n > READ_MAX) n = READ_MAX;
            if (n > fill) n = fill;
            p = rd_ptr;
            if (p >= cap) p = 0;
            for (int i = 0; i < n; i++) begin
               got_bytes.push_back(byte_store[RING_AW'(p)]);
               p = ring_advance(p, 1, cap);
            end
            if (r.consume) begin
               rd_ptr = p;
               fill  -= n;
            end
            if (r.no_copy || n == 0) begin
               push_result(KIND_COUNT, STAT_OK, '0, n, 0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++)
                  push_result(KIND_BYTE, STAT_OK, got_bytes[i], n, 0, (i + 1 == n));
            end
         end
      endtask

      task compare_field(string name, int unsigned got, int unsigned want);
         if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      task check_result(brf_rsp_type got);
         brf_rsp_type want;
         if (expected_results.size() == 0) begin
            report("result arrived with nothing expected");
            return;
         end
         want = expected_results.pop_front();
         compare_field("kind", 32'(got.kind), 32'(want.kind));
         compare_field("status", 32'(got.status), 32'(want.status));
         compare_field("read_data", 32'(got.read_data), 32'(want.read_data));
         compare_field("returned_count", 32'(got.returned_count), 32'(want.returned_count));
         compare_field("dropped_count", 32'(got.dropped_count), 32'(want.dropped_count));
         compare_field("fill_level", 32'(got.fill_level), 32'(want.fill_level));
         compare_field("last", 32'(got.last), 32'(want.last));
      endtask
   endclass

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   brf_req_type       req_data    = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   brf_rsp_type       rsp_data;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   ring_scoreboard sb;
   int unsigned    cycle_count = 0;
   int             stall_mode  = 0;
   int             stall_run   = 0;
   logic [7:0]     stall_mask  = '0;
   int             burst_left  = 0;
   bit             gaps_on     = 1'b1;

   byte_ring_fifo_with_overflow_policy i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver stall pattern, switching to a randomly picked style at regular intervals
   always @(posedge clock) begin
      if (cycle_count % 97 == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_mask = 8'($urandom);
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= stall_mask[3'(cycle_count)];
         default: begin
            if (stall_run > 0) stall_run--;
            else if ($urandom_range(0, 5) == 0) stall_run = $urandom_range(1, 8);
            rsp_stall <= (stall_run > 0);
         end
      endcase
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // one item on the request channel, with bursts and gaps
   task automatic send_req(input brf_req_type item);
      int gap;
      gap = 0;
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 6);
         end
         burst_left--;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(item);
   endtask

   task automatic put_byte(input logic start, input int unsigned len,
                           input logic [DATA_W-1:0] value);
      brf_req_type r;
      r             = brf_req_type'($urandom);
      r.cmd         = CMD_PUT;
      r.start_block = start;
      r.block_len   = LEN_W'(len);
      r.data        = value;
      send_req(r);
   endtask

   task automatic read_req(input int unsigned count, input logic consume, input logic no_copy);
      brf_req_type r;
      r            = brf_req_type'($urandom);
      r.cmd        = CMD_READ;
      r.read_count = RCNT_W'(count);
      r.consume    = consume;
      r.no_copy    = no_copy;
      send_req(r);
   endtask

   // block start plus some of its bytes; fewer than len leaves it open
   task automatic put_block(input int unsigned len, input int unsigned sent);
      put_byte(1'b1, len, DATA_W'($urandom));
      for (int i = 1; i < sent; i++) put_byte(1'b0, $urandom, DATA_W'($urandom));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // apb write: setup phase, then access phase, then back to idle
   task automatic write_reg(input logic idx, input logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_config(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_phase(input int unsigned capacity, input logic mode);
      wait_idle();
      write_reg(REG_MODE, CSR_DW'(mode));
      write_reg(REG_CAPACITY, capacity);
      gaps_on = ($urandom_range(0, 3) != 0);
   endtask

   // mostly well-formed blocks and reads, some noise
   task automatic run_random(input int unsigned count);
      int unsigned done;
      int unsigned cap;
      int unsigned choice;
      int unsigned len;
      int unsigned sent;
      int unsigned hi;
      done = 0;
      while (done < count) begin
         cap    = sb.eff_cap();
         choice = $urandom_range(0, 99);
         if (choice < 50) begin
            hi  = (cap < 8) ? cap : 8;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, cap) : $urandom_range(1, hi);
            // long blocks are cut short and left open
            sent = (len > 48) ? $urandom_range(1, 8) : len;
            put_block(len, sent);
            done += sent;
         end else if (choice < 80) begin
            hi = (sb.fill + 2 > 127) ? 127 : sb.fill + 2;
            read_req(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, hi),
                     ($urandom_range(0, 3) != 0), ($urandom_range(0, 4) == 0));
            done++;
         end else begin
            case ($urandom_range(0, 3))
               0: begin
                  put_byte(1'b0, $urandom, DATA_W'($urandom));
                  done++;
               end
               1: begin
                  len = $urandom_range(0, 1) ? 0 : $urandom_range(cap + 1, 2047);
                  put_byte(1'b1, len, DATA_W'($urandom));
                  done++;
               end
               2: begin
                  // abandoned block
                  len  = (cap >= 2) ? $urandom_range(2, cap) : 1;
                  sent = (len > 1) ? $urandom_range(1, (len - 1 > 6) ? 6 : len - 1) : 1;
                  put_block(len, sent);
                  done += sent;
               end
               default: begin
                  // block as long as the whole ring
                  sent = (cap > 6) ? $urandom_range(1, 6) : cap;
                  put_block(cap, sent);
                  done += sent;
               end
            endcase
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: defaults, reject mode, full-size ring
      put_byte(1'b0, 5, 8'h00);
      read_req(127, 1'b1, 1'b0);
      put_byte(1'b1, 0, 8'h11);
      put_byte(1'b1, 2047, 8'h22);
      put_byte(1'b1, 3, 8'h00);
      put_byte(1'b0, 0, 8'hFF);
      put_byte(1'b0, 0, 8'h5A);
      put_byte(1'b0, 1, 8'h33);
      read_req(127, 1'b0, 1'b0);
      read_req(2, 1'b0, 1'b1);
      put_byte(1'b1, 1024, 8'h44);
      put_byte(1'b1, 4, 8'hA5);
      put_byte(1'b0, 0, 8'h3C);
      put_byte(1'b1, 2, 8'h81);
      put_byte(1'b0, 0, 8'h7E);
      read_req(64, 1'b1, 1'b0);
      read_req(1, 1'b1, 1'b0);
      put_byte(1'b1, 1024, 8'hC3);
      read_req(127, 1'b1, 1'b0);

      // directed: drop mode on a tiny ring
      set_phase(3, MODE_DROP);
      put_byte(1'b1, 3, 8'h01);
      put_byte(1'b0, 0, 8'h02);
      put_byte(1'b0, 0, 8'h03);
      put_byte(1'b1, 2, 8'h04);
      put_byte(1'b0, 0, 8'h05);
      read_req(64, 1'b1, 1'b0);

      // random phases across capacities and modes
      set_phase(5, MODE_DROP);
      run_random(PHASE_ITEMS);
      set_phase(0, MODE_REJECT);
      run_random(PHASE_ITEMS);
      set_phase(2047, MODE_DROP);
      run_random(PHASE_ITEMS);
      set_phase(1, MODE_DROP);
      run_random(PHASE_ITEMS);
      set_phase(16, MODE_REJECT);
      run_random(PHASE_ITEMS);
      set_phase(1025, MODE_REJECT);
      run_random(PHASE_ITEMS);
      set_phase(40, MODE_DROP);
      run_random(PHASE_ITEMS);
      set_phase(9, MODE_REJECT);
      run_random(PHASE_ITEMS);

      // drain and finish
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_results.size() != 0)
         sb.report($sformatf("%0d expected results never arrived", sb.expected_results.size()));
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/brf_pkg.sv
hdl/brf_csr.sv
hdl/brf_ram.sv
hdl/brf_ctrl.sv
hdl/byte_ring_fifo_with_overflow_policy.sv
tb/tb_top.sv
